[design/rhc_pkg.sv]
// rhc_pkg: shared types and constants for the rgb to hsv converter
// no dependencies; imported by rhc_front, rhc_div_cell and the top level

package rhc_pkg;

	// control bits that travel beside each item down the cell chain
	typedef struct packed {
		logic valid;
		logic grey;
		logic black;
	} rhc_ctl_t;

	// hue in whole degrees needs this many bits (0 to 360)
	localparam int HUE_INT_BITS = 9;

	// hue offsets per largest channel, rotated by 120 degrees
	localparam int HUE_BASE_RED   = 120;
	localparam int HUE_BASE_GREEN = 240;
	localparam int HUE_BASE_BLUE  = 360;
	localparam int HUE_SLOPE      = 60;
	localparam int HUE_TURN       = 360;

endpackage

[design/rgb_to_hsv_convert_unit.sv]
// rgb_to_hsv_convert_unit: top level, front stage, chain of division cells, output register
// depends on rhc_pkg, rhc_front and rhc_div_cell

// Converts one pixel per clock from red/green/blue to hue, saturation and
// brightness. busy is never raised, so a new item may be started in every
// cycle. Each item comes out on hue/saturation/brightness with done high for
// exactly one cycle; results leave in start order. Each item passes through one
// input stage, the chain of division cells (one quotient bit per cell) and one
// output register. The receiver cannot stall the block and must take each result
// in the cycle it is shown.

module rgb_to_hsv_convert_unit #(
	parameter int CHANNEL_BITS  = 8,
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               start,
	output logic                                               busy,
	input  logic [CHANNEL_BITS-1:0]                            red,
	input  logic [CHANNEL_BITS-1:0]                            green,
	input  logic [CHANNEL_BITS-1:0]                            blue,
	output logic                                               done,
	output logic [rhc_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0]     hue,
	output logic [CHANNEL_BITS-1:0]                            saturation,
	output logic [CHANNEL_BITS-1:0]                            brightness
);
	import rhc_pkg::*;

	localparam int CB  = CHANNEL_BITS;
	localparam int HW  = HUE_INT_BITS + HUE_FRAC_BITS;
	localparam int QW  = (HW > CB) ? HW : CB;
	localparam int LAT = QW + 2;
	localparam logic [HW-1:0] HUE_MAX = HW'(HUE_TURN) << HUE_FRAC_BITS;

	rhc_ctl_t      ctl_c     [0:QW];
	logic [CB-1:0] bright_c  [0:QW];
	logic [CB-1:0] hue_div_c [0:QW];
	logic [CB-1:0] hue_rem_c [0:QW];
	logic [QW-1:0] hue_rest_c[0:QW];
	logic [QW-1:0] hue_quo_c [0:QW];
	logic [CB-1:0] sat_rem_c [0:QW];
	logic [QW-1:0] sat_rest_c[0:QW];
	logic [QW-1:0] sat_quo_c [0:QW];

	logic          done_q;
	logic [HW-1:0] hue_q;
	logic [CB-1:0] sat_q;
	logic [CB-1:0] bright_q;

	assign busy = 1'b0;

	rhc_front #(
		.CB (CB),
		.HF (HUE_FRAC_BITS),
		.QW (QW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.ctl_s1      (ctl_c[0]),
		.bright_s1   (bright_c[0]),
		.hue_div_s1  (hue_div_c[0]),
		.hue_rem_s1  (hue_rem_c[0]),
		.hue_rest_s1 (hue_rest_c[0]),
		.sat_rem_s1  (sat_rem_c[0]),
		.sat_rest_s1 (sat_rest_c[0])
	);

	assign hue_quo_c[0] = '0;
	assign sat_quo_c[0] = '0;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		rhc_div_cell #(
			.CB (CB),
			.QW (QW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl_in      (ctl_c[i]),
			.bright_in   (bright_c[i]),
			.hue_div_in  (hue_div_c[i]),
			.hue_rem_in  (hue_rem_c[i]),
			.hue_rest_in (hue_rest_c[i]),
			.hue_quo_in  (hue_quo_c[i]),
			.sat_rem_in  (sat_rem_c[i]),
			.sat_rest_in (sat_rest_c[i]),
			.sat_quo_in  (sat_quo_c[i]),
			.ctl_q       (ctl_c[i+1]),
			.bright_q    (bright_c[i+1]),
			.hue_div_q   (hue_div_c[i+1]),
			.hue_rem_q   (hue_rem_c[i+1]),
			.hue_rest_q  (hue_rest_c[i+1]),
			.hue_quo_q   (hue_quo_c[i+1]),
			.sat_rem_q   (sat_rem_c[i+1]),
			.sat_rest_q  (sat_rest_c[i+1]),
			.sat_quo_q   (sat_quo_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_c[QW].valid;
		end
	end

	// grey and black pixels divided by zero, so their quotients are replaced
	always_ff @(posedge clk) begin
		hue_q    <= ctl_c[QW].grey ? '0 : hue_quo_c[QW][HW-1:0];
		sat_q    <= ctl_c[QW].black ? '0 : sat_quo_c[QW][CB-1:0];
		bright_q <= bright_c[QW];
	end

	assign done       = done_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("started item did not finish on time");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hue <= HUE_MAX))
		else $error("hue above a full turn");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (brightness == '0)) |-> ((saturation == '0) && (hue == '0)))
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

[design/rhc_front.sv]
// rhc_front: first pipeline stage, max/min, hue numerator and both dividends
// depends on rhc_pkg

module rhc_front #(
	parameter int CB = 8,
	parameter int HF = 6,
	parameter int QW = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CB-1:0]       red,
	input  logic [CB-1:0]       green,
	input  logic [CB-1:0]       blue,
	output rhc_pkg::rhc_ctl_t   ctl_s1,
	output logic [CB-1:0]       bright_s1,
	output logic [CB-1:0]       hue_div_s1,
	output logic [CB-1:0]       hue_rem_s1,
	output logic [QW-1:0]       hue_rest_s1,
	output logic [CB-1:0]       sat_rem_s1,
	output logic [QW-1:0]       sat_rest_s1
);
	import rhc_pkg::*;

	localparam int DW   = QW + CB;
	localparam int NUMW = CB + 11;
	localparam int NUMU = CB + HUE_INT_BITS;

	logic                   sel_red;
	logic                   sel_green;
	logic [CB-1:0]          mx;
	logic [CB-1:0]          mn;
	logic [CB-1:0]          q;
	logic signed [NUMW-1:0] qs;
	logic signed [NUMW-1:0] base;
	logic signed [NUMW-1:0] diff;
	logic signed [NUMW-1:0] num_raw;
	logic signed [NUMW-1:0] turn;
	logic signed [NUMW-1:0] num_w;
	logic [NUMU-1:0]        num_u;
	logic [DW-1:0]          hue_n;
	logic [DW-1:0]          sat_n;
	logic [2*CB-1:0]        sat_prod;

	// ties go to red, then green
	assign sel_red   = (red >= green) && (red >= blue);
	assign sel_green = !sel_red && (green >= blue);

	always_comb begin
		mn = (red <= green) ? red : green;
		if (blue < mn) begin
			mn = blue;
		end
		priority if (sel_red) begin
			mx   = red;
			base = signed'(NUMW'(HUE_BASE_RED));
			diff = signed'(NUMW'(green)) - signed'(NUMW'(blue));
		end else if (sel_green) begin
			mx   = green;
			base = signed'(NUMW'(HUE_BASE_GREEN));
			diff = signed'(NUMW'(blue)) - signed'(NUMW'(red));
		end else begin
			mx   = blue;
			base = signed'(NUMW'(HUE_BASE_BLUE));
			diff = signed'(NUMW'(red)) - signed'(NUMW'(green));
		end
	end

	assign q       = mx - mn;
	assign qs      = signed'(NUMW'(q));
	assign num_raw = base * qs + signed'(NUMW'(HUE_SLOPE)) * diff;
	assign turn    = signed'(NUMW'(HUE_TURN)) * qs;
	// above a full turn wraps down, exactly a full turn is kept
	assign num_w   = (num_raw > turn) ? (num_raw - turn) : num_raw;
	assign num_u   = num_w[NUMU-1:0];
	assign hue_n   = DW'(num_u) << HF;

	// full scale times q, full scale being all ones
	assign sat_prod = {q, {CB{1'b0}}} - (2*CB)'(q);
	assign sat_n    = DW'(sat_prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start;
			ctl_s1.grey  <= (q == '0);
			ctl_s1.black <= (mx == '0);
		end
	end

	always_ff @(posedge clk) begin
		bright_s1   <= mx;
		hue_div_s1  <= q;
		hue_rem_s1  <= hue_n[DW-1:QW];
		hue_rest_s1 <= hue_n[QW-1:0];
		sat_rem_s1  <= sat_n[DW-1:QW];
		sat_rest_s1 <= sat_n[QW-1:0];
	end

endmodule

[design/rhc_div_cell.sv]
// rhc_div_cell: one restoring division step for hue and saturation lanes
// depends on rhc_pkg; instantiated in a chain by the top level

module rhc_div_cell #(
	parameter int CB = 8,
	parameter int QW = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rhc_pkg::rhc_ctl_t   ctl_in,
	input  logic [CB-1:0]       bright_in,
	input  logic [CB-1:0]       hue_div_in,
	input  logic [CB-1:0]       hue_rem_in,
	input  logic [QW-1:0]       hue_rest_in,
	input  logic [QW-1:0]       hue_quo_in,
	input  logic [CB-1:0]       sat_rem_in,
	input  logic [QW-1:0]       sat_rest_in,
	input  logic [QW-1:0]       sat_quo_in,
	output rhc_pkg::rhc_ctl_t   ctl_q,
	output logic [CB-1:0]       bright_q,
	output logic [CB-1:0]       hue_div_q,
	output logic [CB-1:0]       hue_rem_q,
	output logic [QW-1:0]       hue_rest_q,
	output logic [QW-1:0]       hue_quo_q,
	output logic [CB-1:0]       sat_rem_q,
	output logic [QW-1:0]       sat_rest_q,
	output logic [QW-1:0]       sat_quo_q
);
	import rhc_pkg::*;

	logic [CB:0]   hue_t;
	logic [CB:0]   hue_sub;
	logic          hue_ge;
	logic [CB:0]   sat_t;
	logic [CB:0]   sat_sub;
	logic          sat_ge;

	// bring down the next dividend bit and try the divisor
	assign hue_t   = {hue_rem_in, hue_rest_in[QW-1]};
	assign hue_sub = hue_t - {1'b0, hue_div_in};
	assign hue_ge  = (hue_t >= {1'b0, hue_div_in});

	// saturation divides by the largest channel
	assign sat_t   = {sat_rem_in, sat_rest_in[QW-1]};
	assign sat_sub = sat_t - {1'b0, bright_in};
	assign sat_ge  = (sat_t >= {1'b0, bright_in});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		bright_q   <= bright_in;
		hue_div_q  <= hue_div_in;
		hue_rem_q  <= hue_ge ? hue_sub[CB-1:0] : hue_t[CB-1:0];
		hue_rest_q <= {hue_rest_in[QW-2:0], 1'b0};
		hue_quo_q  <= {hue_quo_in[QW-2:0], hue_ge};
		sat_rem_q  <= sat_ge ? sat_sub[CB-1:0] : sat_t[CB-1:0];
		sat_rest_q <= {sat_rest_in[QW-2:0], 1'b0};
		sat_quo_q  <= {sat_quo_in[QW-2:0], sat_ge};
	end

endmodule

[bench/rgb_to_hsv_convert_checker.sv]
// rgb_to_hsv_convert_checker: watches the pixel and result channels of the converter,
// predicts hue, saturation and brightness for each accepted pixel and compares in order
// depends on rhc_pkg
`timescale 1ns / 100ps

module rgb_to_hsv_convert_checker #(
	parameter int CHANNEL_BITS  = 8,
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic                                           busy,
	input  logic [CHANNEL_BITS-1:0]                        red,
	input  logic [CHANNEL_BITS-1:0]                        green,
	input  logic [CHANNEL_BITS-1:0]                        blue,
	input  logic                                           done,
	input  logic [rhc_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] hue,
	input  logic [CHANNEL_BITS-1:0]                        saturation,
	input  logic [CHANNEL_BITS-1:0]                        brightness,
	output int                                             fails,
	output int                                             waiting
);

	localparam int HUE_BITS = rhc_pkg::HUE_INT_BITS + HUE_FRAC_BITS;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] r;
		logic [CHANNEL_BITS-1:0] g;
		logic [CHANNEL_BITS-1:0] b;
		logic [HUE_BITS-1:0]     hue;
		logic [CHANNEL_BITS-1:0] sat;
		logic [CHANNEL_BITS-1:0] val;
	} hsv_pixel_t;

	hsv_pixel_t expected_hsv[$];
	hsv_pixel_t want;
	int         mismatch_count = 0;
	int         result_index   = 0;

	function automatic hsv_pixel_t hsv_of(logic [CHANNEL_BITS-1:0] r,
		logic [CHANNEL_BITS-1:0] g, logic [CHANNEL_BITS-1:0] b);
		hsv_pixel_t p;
		longint     full;
		longint     mx;
		longint     mn;
		longint     q;
		longint     num;
		full = (longint'(1) << CHANNEL_BITS) - 1;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		q = mx - mn;
		p.r = r;
		p.g = g;
		p.b = b;
		p.val = mx[CHANNEL_BITS-1:0];
		p.sat = (mx != 0) ? CHANNEL_BITS'((full * q) / mx) : '0;
		if (q == 0) begin
			p.hue = '0;
		end else begin
			// ties on the largest channel go to red first, then green
			if (r == mx) begin
				num = rhc_pkg::HUE_BASE_RED * q
					+ rhc_pkg::HUE_SLOPE * (longint'(g) - longint'(b));
			end else if (g == mx) begin
				num = rhc_pkg::HUE_BASE_GREEN * q
					+ rhc_pkg::HUE_SLOPE * (longint'(b) - longint'(r));
			end else begin
				num = rhc_pkg::HUE_BASE_BLUE * q
					+ rhc_pkg::HUE_SLOPE * (longint'(r) - longint'(g));
			end
			// wrap only above a full turn, exactly 360 stays
			if (num > rhc_pkg::HUE_TURN * q)
				num = num - rhc_pkg::HUE_TURN * q;
			p.hue = HUE_BITS'((num << HUE_FRAC_BITS) / q);
		end
		return p;
	endfunction

	task automatic report(string what, longint got, longint exp_v);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t mismatch on result %0d, %s: got %0d, want %0d (rgb %0d %0d %0d)",
				$time, result_index, what, got, exp_v, want.r, want.g, want.b);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_hsv.push_back(hsv_of(red, green, blue));
			if (done) begin
				if (expected_hsv.size() == 0) begin
					want = '0;
					report("result with no pixel waiting", hue, 0);
				end else begin
					want = expected_hsv.pop_front();
					if (hue !== want.hue)
						report("hue", hue, want.hue);
					if (saturation !== want.sat)
						report("saturation", saturation, want.sat);
					if (brightness !== want.val)
						report("brightness", brightness, want.val);
				end
				result_index++;
			end
		end
		fails   <= mismatch_count;
		waiting <= expected_hsv.size();
	end

endmodule

[bench/rgb_to_hsv_convert_unit_tb.sv]
// rgb_to_hsv_convert_unit_tb: drives pixels into the converter in random bursts and gives the verdict
// depends on rgb_to_hsv_convert_unit, rgb_to_hsv_convert_checker and rhc_pkg
`timescale 1ns / 100ps

module rgb_to_hsv_convert_unit_tb;

	localparam int CHANNEL_BITS   = 8;
	localparam int HUE_FRAC_BITS  = 6;
	localparam int HUE_BITS       = rhc_pkg::HUE_INT_BITS + HUE_FRAC_BITS;
	localparam int FULL           = (1 << CHANNEL_BITS) - 1;
	localparam int LATENCY        = ((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS) + 2;
	localparam int RANDOM_PIXELS  = 1750;
	localparam int WATCHDOG_LIMIT = 500;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    start  = 1'b0;
	logic [CHANNEL_BITS-1:0] red    = '0;
	logic [CHANNEL_BITS-1:0] green  = '0;
	logic [CHANNEL_BITS-1:0] blue   = '0;
	logic                    busy;
	logic                    done;
	logic [HUE_BITS-1:0]     hue;
	logic [CHANNEL_BITS-1:0] saturation;
	logic [CHANNEL_BITS-1:0] brightness;
	int                      fails;
	int                      waiting;
	int                      burst_left = 0;
	int                      idle_cycles = 0;

	rgb_to_hsv_convert_unit #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.done      (done),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness)
	);

	rgb_to_hsv_convert_checker #(
		.CHANNEL_BITS (CHANNEL_BITS),
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) hsv_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.done      (done),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.fails     (fails),
		.waiting   (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ends the run if nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_pixel(int r, int g, int b);
		int gap;
		start <= 1'b1;
		red   <= CHANNEL_BITS'(r);
		green <= CHANNEL_BITS'(g);
		blue  <= CHANNEL_BITS'(b);
		do @(posedge clk); while (busy);
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 7);
		end else begin
			burst_left--;
		end
	endtask

	function automatic int pick_extreme();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return FULL / 2;
			3: return FULL / 2 + 1;
			4: return FULL - 1;
			default: return FULL;
		endcase
	endfunction

	task automatic push_random_pixel();
		int top;
		int low;
		int r;
		int g;
		int b;
		top = $urandom_range(0, FULL);
		low = $urandom_range(0, top);
		r = $urandom_range(0, FULL);
		g = $urandom_range(0, FULL);
		b = $urandom_range(0, FULL);
		case ($urandom_range(0, 9))
			6: begin
				// ties on the largest channel, or all equal
				case ($urandom_range(0, 3))
					0: begin r = top; g = top; b = low; end
					1: begin r = low; g = top; b = top; end
					2: begin r = top; g = low; b = top; end
					default: begin r = top; g = top; b = top; end
				endcase
			end
			7: begin
				r = pick_extreme();
				g = pick_extreme();
				b = pick_extreme();
			end
			8: begin
				r = $urandom_range(0, 3);
				g = $urandom_range(0, 3);
				b = $urandom_range(0, 3);
			end
			9: begin
				// nearly grey, small q
				r = top;
				g = (top >= 2) ? top - $urandom_range(0, 2) : top;
				b = (top >= 2) ? top - $urandom_range(0, 2) : top;
			end
			default: ;
		endcase
		push_pixel(r, g, b);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_pixel(0, 0, 0);                     // black
		push_pixel(FULL, FULL, FULL);            // white
		push_pixel(100, 100, 100);               // grey
		push_pixel(FULL, 0, 0);                  // pure red
		push_pixel(0, FULL, 0);                  // pure green
		push_pixel(0, 0, FULL);                  // pure blue, hue lands on exactly 360
		push_pixel(1, 0, 0);
		push_pixel(0, 0, 1);
		push_pixel(FULL, FULL, 0);               // red and green tie
		push_pixel(0, FULL, FULL);               // green and blue tie
		push_pixel(FULL, 0, FULL);               // red and blue tie
		push_pixel(200, 0, FULL);                // blue largest, wraps past 360
		push_pixel(FULL, 0, 200);                // red largest, blue above green
		push_pixel(FULL, 200, 0);
		push_pixel(0, FULL, 200);
		push_pixel(200, FULL, 0);
		push_pixel(FULL, FULL - 1, FULL - 1);    // tiny saturation
		push_pixel(FULL, FULL - 1, FULL);
		push_pixel(1, 1, 0);
		push_pixel(FULL - 1, FULL, FULL - 1);
		push_pixel(170, 85, 85);

		repeat (RANDOM_PIXELS) push_random_pixel();

		start <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
